[rtl/speck128_128_block_cipher_assert.svh]
// ----------------------------------------------------------------------------
// Speck128/128 assertion macros
// Concurrent assertion helpers for the cipher; they compile to nothing in
// synthesis.
// ----------------------------------------------------------------------------
`ifndef SPECK128_128_BLOCK_CIPHER_ASSERT_SVH
`define SPECK128_128_BLOCK_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define SPK_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("speck128 assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SPK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("speck128 assertion failed");

`else

`define SPK_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SPK_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/spk_pkg.sv]
// ----------------------------------------------------------------------------
// Speck128/128 package
// Sequencer state type, register indexes, mode codes and rotate amounts.
// ----------------------------------------------------------------------------
package spk_pkg;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXPAND = 5'b00010,
    ST_FETCH  = 5'b00100,
    ST_ROUND  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  // Register indexes, taken from paddr[3] (registers sit 8 bytes apart).
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // Rotate-right amounts of the round and of its inverse.
  localparam int ROT_X  = 8;
  localparam int ROT_Y  = 61;
  localparam int ROT_DX = 56;
  localparam int ROT_DY = 3;

  function automatic logic [63:0] rotr64(input logic [63:0] v, input int n);
    return (v >> n) | (v << (64 - n));
  endfunction

endpackage

[rtl/spk_ram.sv]
// ----------------------------------------------------------------------------
// Speck128/128 generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module spk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/speck128_128_block_cipher.sv]
// An accepted input word passes ST_FETCH, ST_ROUND and ST_DONE on its way
// to a valid output word, after ST_EXPAND for the first block after reset or
// a key write. A new word is taken only in ST_IDLE, once the last has left
// ST_DONE: one 64-bit round unit runs one round per cycle off the key RAM port.
// Reset (rst, synchronous) clears the key registers and the schedule flag;
// the round key RAM is not cleared, it is rebuilt before its first use.
// ----------------------------------------------------------------------------
// Speck128/128 block cipher
// ECB encryption and decryption with an on-chip round key schedule. One
// shared round unit does both the key expansion and the cipher rounds.
// ----------------------------------------------------------------------------
`include "speck128_128_block_cipher_assert.svh"

module speck128_128_block_cipher
  import spk_pkg::*;
#(
  parameter int ROUND_COUNT = 32
) (
  input  logic         clk,
  input  logic         rst,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  // input words
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // word_x [63:0], word_y [127:64]
  input  logic [0:0]   s_tuser,   // mode [0]
  // output words
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // out_x [63:0], out_y [127:64]
);

  localparam int CW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [CW-1:0] EXP_LAST   = CW'((ROUND_COUNT > 1) ? ROUND_COUNT - 2 : 0);
  localparam logic [CW-1:0] ROUND_LAST = CW'(ROUND_COUNT - 1);
  localparam logic [CW:0]   KEY_TOP    = (CW+1)'(ROUND_COUNT - 1);
  localparam bit            SINGLE     = (ROUND_COUNT == 1);

  state_t        state, state_next;
  logic [CW-1:0] cnt;
  logic          sched_ready;
  logic [63:0]   key_low, key_high;
  logic [63:0]   blk_x, blk_y;
  logic          mode;
  logic [63:0]   sch_aux, sch_rk;

  logic          s_accept, cfg_wr, cfg_idx, out_free;
  logic [CW:0]   nxt;

  logic          ram_we;
  logic [CW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  logic [63:0]   ua, ub, rkey, dy, op_a, op_b, sum, nx, ny;
  logic          dec;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign cfg_idx  = paddr[3];
  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign nxt      = {1'b0, cnt} + (CW+1)'(1);

  always_comb begin
    unique case (cfg_idx)
      REG_KEY_LOW:  prdata = key_low;
      REG_KEY_HIGH: prdata = key_high;
      default:      prdata = key_low;
    endcase
  end

  // Shared round unit. In expansion it runs the encrypt round on (aux, rk)
  // with the round index as key; decryption reuses the adder as a subtractor.
  always_comb begin
    ua   = (state == ST_EXPAND) ? sch_aux : blk_x;
    ub   = (state == ST_EXPAND) ? sch_rk  : blk_y;
    rkey = (state == ST_EXPAND) ? {{(64-CW){1'b0}}, cnt} : ram_rdata;
    dec  = (state == ST_ROUND) && (mode == MODE_DEC);
    dy   = rotr64(ua ^ ub, ROT_DY);
    op_a = dec ? (ua ^ rkey) : rotr64(ua, ROT_X);
    op_b = dec ? ~dy : ub;
    sum  = op_a + op_b + {63'b0, dec};
    nx   = dec ? rotr64(sum, ROT_DX) : (sum ^ rkey);
    ny   = dec ? dy : (rotr64(ub, ROT_Y) ^ nx);
  end

  // Key RAM: key_low goes to entry zero when a block arrives without a
  // valid schedule; the expansion fills the rest. Reads run one round ahead.
  always_comb begin
    ram_we    = (s_accept & ~sched_ready) | (state == ST_EXPAND);
    ram_waddr = s_accept ? '0 : nxt[CW-1:0];
    ram_wdata = s_accept ? key_low : ny;
    if (state == ST_FETCH) begin
      ram_raddr = (mode == MODE_DEC) ? ROUND_LAST : '0;
    end else begin
      ram_raddr = (mode == MODE_DEC) ? CW'(KEY_TOP - nxt) : nxt[CW-1:0];
    end
  end

  spk_ram #(
    .WIDTH (64),
    .DEPTH (ROUND_COUNT),
    .AW    (CW)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_accept) begin
          state_next = (!sched_ready && !SINGLE) ? ST_EXPAND : ST_FETCH;
        end
      end
      ST_EXPAND: begin
        if (cnt == EXP_LAST) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_ROUND;
      ST_ROUND: begin
        if (cnt == ROUND_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      sched_ready <= 1'b0;
      key_low     <= '0;
      key_high    <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;

      if (s_accept || state == ST_FETCH || (state == ST_EXPAND && cnt == EXP_LAST)) begin
        cnt <= '0;
      end else if (state == ST_EXPAND || state == ST_ROUND) begin
        cnt <= nxt[CW-1:0];
      end

      // A key write invalidates the schedule and wins over its completion.
      if (cfg_wr) begin
        sched_ready <= 1'b0;
        if (cfg_idx == REG_KEY_HIGH) begin
          key_high <= pwdata;
        end else begin
          key_low <= pwdata;
        end
      end else if ((state == ST_EXPAND && cnt == EXP_LAST) || (s_accept && SINGLE)) begin
        sched_ready <= 1'b1;
      end

      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      blk_x   <= s_tdata[63:0];
      blk_y   <= s_tdata[127:64];
      mode    <= s_tuser[0];
      sch_aux <= key_high;
      sch_rk  <= key_low;
    end else if (state == ST_EXPAND) begin
      sch_aux <= nx;
      sch_rk  <= ny;
    end else if (state == ST_ROUND) begin
      blk_x <= nx;
      blk_y <= ny;
    end
    if (state == ST_DONE && out_free) begin
      m_tdata <= {blk_y, blk_x};
    end
  end

  `SPK_ASSERT_SAME(a_round_needs_sched, clk, rst, state == ST_ROUND, sched_ready)
  `SPK_ASSERT_SAME(a_no_write_in_round, clk, rst, state == ST_ROUND, !ram_we)
  `SPK_ASSERT_SAME(a_round_cnt_range, clk, rst, state == ST_ROUND, cnt <= ROUND_LAST)
  `SPK_ASSERT_NEXT(a_done_delivers, clk, rst, state == ST_DONE && out_free, m_tvalid && state == ST_IDLE)
  `SPK_ASSERT_NEXT(a_fetch_to_round, clk, rst, state == ST_FETCH, state == ST_ROUND && cnt == '0)

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Speck128/128 block cipher testbench
// Checks the cipher against a predictor of the round and key schedule that
// runs beside it. A directed table covers key and data extremes, both modes
// and the published test vector. Then comes a long random part with rekeys
// between phases, random stalls on both streams and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import spk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROUNDS = 32;
  localparam int RANDOM_WORDS = 1135;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [63:0] ox;
    logic [63:0] oy;
  } cipher_out_t;

  // One row of the directed table. A row with new_key set drains the block
  // and loads both key words before its word is sent.
  typedef struct {
    logic        new_key;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic        md;
    logic [63:0] wx;
    logic [63:0] wy;
    logic        known;
    logic [63:0] ex;
    logic [63:0] ey;
  } dir_row_t;

  localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] TV_KEY_LO = 64'h0706050403020100;
  localparam logic [63:0] TV_KEY_HI = 64'h0f0e0d0c0b0a0908;
  localparam logic [63:0] TV_PT_X = 64'h6c61766975716520;
  localparam logic [63:0] TV_PT_Y = 64'h7469206564616d20;
  localparam logic [63:0] TV_CT_X = 64'ha65d985179783265;
  localparam logic [63:0] TV_CT_Y = 64'h7860fedf5c570d18;
  localparam int N_DIR = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [127:0] s_tdata = '0;   // word_x [63:0], word_y [127:64]
  logic [0:0] s_tuser = '0;     // mode [0]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;        // out_x [63:0], out_y [127:64]

  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int mismatches = 0;

  // Predictor state.
  logic [63:0] key_lo_q = '0;
  logic [63:0] key_hi_q = '0;
  logic [63:0] round_keys [ROUNDS];
  logic sched_ok = 1'b0;
  cipher_out_t pending_out [$];

  dir_row_t dir_rows [N_DIR];

  speck128_128_block_cipher #(.ROUND_COUNT(ROUNDS)) uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return ONES;
      2: return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic expand_keys();
    logic [63:0] rk;
    logic [63:0] aux;
    rk = key_lo_q;
    aux = key_hi_q;
    round_keys[0] = rk;
    for (int r = 0; r < ROUNDS - 1; r++) begin
      aux = (rk + rotr(aux, 8)) ^ 64'(r);
      rk = rotr(rk, 61) ^ aux;
      round_keys[r + 1] = rk;
    end
    sched_ok = 1'b1;
  endtask

  task automatic predict_block(input logic md, input logic [63:0] wx, input logic [63:0] wy,
                               output cipher_out_t res);
    logic [63:0] x;
    logic [63:0] y;
    x = wx;
    y = wy;
    if (!sched_ok) expand_keys();
    if (md == MODE_ENC) begin
      for (int r = 0; r < ROUNDS; r++) begin
        x = (rotr(x, 8) + y) ^ round_keys[r];
        y = rotr(y, 61) ^ x;
      end
    end else begin
      for (int r = 0; r < ROUNDS; r++) begin
        y = rotr(x ^ y, 3);
        x = rotr((x ^ round_keys[ROUNDS - 1 - r]) - y, 56);
      end
    end
    res.ox = x;
    res.oy = y;
  endtask

  // Each write is a setup phase and an access phase; the bus is then left idle before the task returns.
  task automatic write_key(input logic idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_KEY_LOW) key_lo_q = val;
    else key_hi_q = val;
    sched_ok = 1'b0;
    @(posedge clk);
  endtask

  // Drains the block, then writes the key words: 0 both low first, 1 both
  // high first, 2 low only, 3 high only.
  task automatic rekey(input logic [1:0] how, input logic [63:0] lo, input logic [63:0] hi);
    s_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    case (how)
      2'd0: begin
        write_key(REG_KEY_LOW, lo);
        write_key(REG_KEY_HIGH, hi);
      end
      2'd1: begin
        write_key(REG_KEY_HIGH, hi);
        write_key(REG_KEY_LOW, lo);
      end
      2'd2: write_key(REG_KEY_LOW, lo);
      default: write_key(REG_KEY_HIGH, hi);
    endcase
  endtask

  task automatic send_word(input logic md, input logic [63:0] wx, input logic [63:0] wy,
                           input logic known, input cipher_out_t typed);
    cipher_out_t res;
    while (!calm && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {wy, wx};
    s_tuser <= md;
    do @(posedge clk); while (!s_tready);
    predict_block(md, wx, wy, res);
    if (known) begin
      pending_out.push_back(typed);
    end else begin
      pending_out.push_back(res);
    end
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    cipher_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_out.size() == 0) begin
        $display("%0t: output word with none expected, got x %h y %h",
                 $time, m_tdata[63:0], m_tdata[127:64]);
        mismatches++;
      end else begin
        want = pending_out.pop_front();
        if (m_tdata[63:0] !== want.ox) begin
          $display("%0t: out_x expected %h got %h", $time, want.ox, m_tdata[63:0]);
          mismatches++;
        end
        if (m_tdata[127:64] !== want.oy) begin
          $display("%0t: out_y expected %h got %h", $time, want.oy, m_tdata[127:64]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cipher_out_t typed;
    int next_rekey;
    dir_rows = '{
      '{1'b0, '0, '0, MODE_ENC, '0, '0, 1'b0, '0, '0},
      '{1'b0, '0, '0, MODE_ENC, ONES, ONES, 1'b0, '0, '0},
      '{1'b0, '0, '0, MODE_DEC, '0, '0, 1'b0, '0, '0},
      '{1'b0, '0, '0, MODE_DEC, ONES, ONES, 1'b0, '0, '0},
      '{1'b0, '0, '0, MODE_ENC, ONES, '0, 1'b0, '0, '0},
      '{1'b0, '0, '0, MODE_DEC, '0, ONES, 1'b0, '0, '0},
      '{1'b1, TV_KEY_LO, TV_KEY_HI, MODE_ENC, TV_PT_X, TV_PT_Y, 1'b1, TV_CT_X, TV_CT_Y},
      '{1'b0, '0, '0, MODE_DEC, TV_CT_X, TV_CT_Y, 1'b1, TV_PT_X, TV_PT_Y},
      '{1'b0, '0, '0, MODE_ENC, '0, '0, 1'b0, '0, '0},
      '{1'b0, '0, '0, MODE_DEC, 64'd1, 64'h8000_0000_0000_0000, 1'b0, '0, '0},
      '{1'b1, ONES, ONES, MODE_ENC, '0, '0, 1'b0, '0, '0},
      '{1'b0, '0, '0, MODE_DEC, ONES, ONES, 1'b0, '0, '0},
      '{1'b0, '0, '0, MODE_ENC, 64'h8000_0000_0000_0000, 64'd1, 1'b0, '0, '0},
      '{1'b1, '0, ONES, MODE_ENC, ONES, '0, 1'b0, '0, '0},
      '{1'b1, ONES, '0, MODE_DEC, '0, ONES, 1'b0, '0, '0},
      '{1'b0, '0, '0, MODE_ENC, TV_PT_X, TV_PT_Y, 1'b0, '0, '0}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].new_key) rekey(2'd0, dir_rows[i].key_lo, dir_rows[i].key_hi);
      typed.ox = dir_rows[i].ex;
      typed.oy = dir_rows[i].ey;
      send_word(dir_rows[i].md, dir_rows[i].wx, dir_rows[i].wy, dir_rows[i].known, typed);
    end

    next_rekey = $urandom_range(100, 200);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == next_rekey) begin
        rekey(2'($urandom_range(3)), pick_word(), pick_word());
        next_rekey = n + $urandom_range(100, 200);
      end
      // A stretch with no stalls on either side, and later one long
      // hold-off of the output so that the input backs up.
      if (n == 300) calm <= 1'b1;
      if (n == 500) calm <= 1'b0;
      if (n == 700) hold_req <= 1'b1;
      send_word(1'($urandom_range(1)), pick_word(), pick_word(), 1'b0, typed);
    end
    s_tvalid <= 1'b0;

    while (pending_out.size() != 0) @(posedge clk);
    repeat (ROUNDS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("%0t: timeout", $time);
    $display("tb NOT OK");
    $finish;
  end

endmodule
